>>> sv/bb3_pkg.sv
// bb3_pkg: shared constants, types and the reciprocal table for the 3x3 box blur
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bb3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WID_W = 11;
  localparam int HGT_W = 13;
  localparam int CFG_W = 13;
  localparam int IDX_W = 1;
  localparam int PIX_W = 24;
  localparam int SUM_W = 12;
  localparam int CNT_W = 4;
  localparam int NUM_W = 13;
  localparam int REC_SHIFT = 18;
  localparam int REC_W = 18;
  localparam int PROD_W = NUM_W + REC_W;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  localparam logic [HGT_W-1:0] HEIGHT_RST = HGT_W'(1024);
  localparam logic [WID_W-1:0] WIDTH_RST  = WID_W'(1024);

  localparam logic [IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    F_IDLE,
    F_PIX,
    F_PIX2,
    F_DR_A,
    F_DR_B,
    F_DR_PUSH
  } bb3_fstate_t;

  // slot = column * 3 + row, column 0 is the leftmost, row 0 the top
  typedef struct packed {
    logic [8:0][PIX_W-1:0] px;
    logic [8:0]            vld;
    logic                  run_last;
    logic                  frame_last;
  } bb3_job_t;

  // ceil(2^18 / (2 * count)), exact quotient for dividends below 2^13
  function automatic logic [REC_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [REC_W-1:0] r;
    unique case (cnt)
      4'd1:    r = 18'd131072;
      4'd2:    r = 18'd65536;
      4'd3:    r = 18'd43691;
      4'd4:    r = 18'd32768;
      4'd5:    r = 18'd26215;
      4'd6:    r = 18'd21846;
      4'd7:    r = 18'd18725;
      4'd8:    r = 18'd16384;
      4'd9:    r = 18'd14564;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/bb3_front.sv
// bb3_front: accepts words, keeps the line stores, window and frame position,
// builds averaging jobs for the queue; uses bb3_pkg
`timescale 1ns / 1ps
`default_nettype none
module bb3_front (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire [bb3_pkg::IDX_W-1:0]     cfg_index,
  input  wire [bb3_pkg::CFG_W-1:0]     cfg_data,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          in_mode,
  input  wire [7:0]                    in_red,
  input  wire [7:0]                    in_green,
  input  wire [7:0]                    in_blue,
  input  wire                          q_room,
  output logic                         q_push,
  output bb3_pkg::bb3_job_t            q_job
);
  import bb3_pkg::*;

  logic [PIX_W-1:0] older_mem [MAX_WIDTH];
  logic [PIX_W-1:0] newer_mem [MAX_WIDTH];

  bb3_fstate_t state_r, state_nxt;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic [COL_W-1:0] drn_r;
  logic             await_r;
  logic [WID_W-1:0] width_r;
  logic [HGT_W-1:0] height_r;

  logic [PIX_W-1:0] px_r;
  logic [PIX_W-1:0] rd_old_r, rd_new_r;
  logic [5:0][PIX_W-1:0] win_r;
  logic [2:0][1:0][PIX_W-1:0] dwin_r;

  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;
  logic [COL_W-1:0] wm1;
  logic [ROW_W-1:0] hm1;
  logic [WID_W-1:0] drn_ext, drn_p1;

  logic acc, px_go, dr_go;
  logic rd_en;
  logic [COL_W-1:0] rd_addr;
  logic px_done, dr_done;
  logic j1, j2, top_ok;
  logic [2:0][PIX_W-1:0] cur;
  bb3_job_t job1, job2, jobd;

  always_comb begin
    if (width_r == '0) begin
      w_eff = WID_W'(1);
    end else if (width_r > WID_W'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = HGT_W'(1);
    end else if (height_r > HGT_W'(MAX_HEIGHT)) begin
      h_eff = HGT_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  assign wm1     = COL_W'(w_eff - WID_W'(1));
  assign hm1     = ROW_W'(h_eff - HGT_W'(1));
  assign drn_ext = {1'b0, drn_r};
  assign drn_p1  = drn_ext + WID_W'(1);

  assign in_ready = (state_r == F_IDLE);
  assign acc      = in_valid && in_ready;
  assign px_go    = acc && !in_mode && !await_r;
  assign dr_go    = acc && in_mode && await_r && (drn_ext < w_eff);

  assign top_ok = (row_r >= ROW_W'(2));
  assign j1     = (row_r != '0) && (col_r != '0);
  assign j2     = (row_r != '0) && (col_r == wm1);
  assign cur[0] = rd_old_r;
  assign cur[1] = rd_new_r;
  assign cur[2] = px_r;

  always_comb begin
    logic rv;
    job1 = '0;
    job2 = '0;
    jobd = '0;
    for (int i = 0; i < 3; i++) begin
      rv = (i != 0) || top_ok;
      job1.px[i]      = win_r[3+i];
      job1.vld[i]     = rv && (col_r >= COL_W'(2));
      job1.px[3+i]    = win_r[i];
      job1.vld[3+i]   = rv;
      job1.px[6+i]    = cur[i];
      job1.vld[6+i]   = rv;
      job2.px[i]      = win_r[i];
      job2.vld[i]     = rv && (col_r != '0);
      job2.px[3+i]    = cur[i];
      job2.vld[3+i]   = rv;
    end
    job1.run_last = !j2;
    job2.run_last = 1'b1;
    for (int k = 0; k < 3; k++) begin
      jobd.px[3*k]     = dwin_r[k][0];
      jobd.px[3*k+1]   = dwin_r[k][1];
    end
    jobd.vld[0] = (drn_r != '0) && (h_eff >= HGT_W'(2));
    jobd.vld[1] = (drn_r != '0);
    jobd.vld[3] = (h_eff >= HGT_W'(2));
    jobd.vld[4] = 1'b1;
    jobd.vld[6] = (drn_p1 < w_eff) && (h_eff >= HGT_W'(2));
    jobd.vld[7] = (drn_p1 < w_eff);
    jobd.run_last   = 1'b1;
    jobd.frame_last = (drn_r == wm1);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (px_go) begin
          state_nxt = F_PIX;
        end else if (dr_go) begin
          if (drn_r == '0) begin
            state_nxt = F_DR_A;
          end else if (drn_p1 < w_eff) begin
            state_nxt = F_DR_B;
          end else begin
            state_nxt = F_DR_PUSH;
          end
        end
      end
      F_PIX: begin
        if (q_room) begin
          state_nxt = (j1 && j2) ? F_PIX2 : F_IDLE;
        end
      end
      F_PIX2: begin
        if (q_room) begin
          state_nxt = F_IDLE;
        end
      end
      F_DR_A: begin
        state_nxt = (w_eff > WID_W'(1)) ? F_DR_B : F_DR_PUSH;
      end
      F_DR_B: begin
        state_nxt = F_DR_PUSH;
      end
      F_DR_PUSH: begin
        if (q_room) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = col_r;
    q_push  = 1'b0;
    q_job   = job1;
    px_done = 1'b0;
    dr_done = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        if (px_go) begin
          rd_en   = 1'b1;
          rd_addr = col_r;
        end else if (dr_go) begin
          rd_en   = (drn_r == '0) || (drn_p1 < w_eff);
          rd_addr = (drn_r == '0) ? '0 : COL_W'(drn_p1);
        end
      end
      F_PIX: begin
        q_push  = q_room && (j1 || j2);
        q_job   = j1 ? job1 : job2;
        px_done = q_room && !(j1 && j2);
      end
      F_PIX2: begin
        q_push  = q_room;
        q_job   = job2;
        px_done = q_room;
      end
      F_DR_A: begin
        rd_en   = (w_eff > WID_W'(1));
        rd_addr = COL_W'(1);
      end
      F_DR_B: begin
        rd_en = 1'b0;
      end
      F_DR_PUSH: begin
        q_push  = q_room;
        q_job   = jobd;
        dr_done = q_room;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_old_r <= older_mem[rd_addr];
      rd_new_r <= newer_mem[rd_addr];
    end
    if (px_done) begin
      older_mem[col_r] <= rd_new_r;
      newer_mem[col_r] <= px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (px_go) begin
      px_r <= {in_blue, in_green, in_red};
    end
    if (px_done) begin
      for (int i = 0; i < 3; i++) begin
        win_r[3+i] <= win_r[i];
        win_r[i]   <= cur[i];
      end
    end
    if (state_r == F_IDLE && dr_go && drn_r != '0) begin
      dwin_r[0] <= dwin_r[1];
      dwin_r[1] <= dwin_r[2];
    end
    if (state_r == F_DR_A) begin
      dwin_r[1] <= {rd_new_r, rd_old_r};
    end
    if (state_r == F_DR_B) begin
      dwin_r[2] <= {rd_new_r, rd_old_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      row_r    <= '0;
      col_r    <= '0;
      drn_r    <= '0;
      await_r  <= 1'b0;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_WIDTH) begin
        width_r <= cfg_data[WID_W-1:0];
      end else begin
        height_r <= cfg_data[HGT_W-1:0];
      end
      row_r   <= '0;
      col_r   <= '0;
      drn_r   <= '0;
      await_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (px_done) begin
        if (col_r == wm1) begin
          col_r <= '0;
          if (row_r == hm1) begin
            row_r   <= '0;
            await_r <= 1'b1;
          end else begin
            row_r <= row_r + ROW_W'(1);
          end
        end else begin
          col_r <= col_r + COL_W'(1);
        end
      end
      if (dr_done) begin
        if (drn_r == wm1) begin
          drn_r   <= '0;
          await_r <= 1'b0;
          row_r   <= '0;
          col_r   <= '0;
        end else begin
          drn_r <= drn_r + COL_W'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/bb3_queue.sv
// bb3_queue: short job queue between front and back
// uses bb3_pkg
`timescale 1ns / 1ps
`default_nettype none
module bb3_queue (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      push,
  input  wire bb3_pkg::bb3_job_t   push_job,
  output logic                     room,
  input  wire                      pop,
  output logic                     avail,
  output bb3_pkg::bb3_job_t        pop_job
);
  import bb3_pkg::*;

  bb3_job_t mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_r, rp_r;
  logic [Q_PTR_W:0]   cnt_r;
  logic do_push, do_pop;

  assign room    = (cnt_r != (Q_PTR_W+1)'(Q_DEPTH));
  assign avail   = (cnt_r != '0);
  assign pop_job = mem_r[rp_r];
  assign do_push = push && room;
  assign do_pop  = pop && avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rp_r <= rp_r + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + (Q_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - (Q_PTR_W+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/bb3_back.sv
// bb3_back: sums the valid window slots, divides by the count with rounding
// and holds the result word; uses bb3_pkg
`timescale 1ns / 1ps
`default_nettype none
module bb3_back (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     q_avail,
  input  wire bb3_pkg::bb3_job_t  q_job,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic [7:0]              out_red,
  output logic [7:0]              out_green,
  output logic [7:0]              out_blue,
  output logic                    out_run_last,
  output logic                    out_frame_last
);
  import bb3_pkg::*;

  logic va_r, vb_r, vo_r;
  logic en_a, en_b, en_o;
  logic [2:0][SUM_W-1:0] sum_a_r, sum_nxt;
  logic [CNT_W-1:0] cnt_a_r, cnt_nxt;
  logic [1:0] fl_a_r, fl_b_r;
  logic [2:0][PROD_W-1:0] prod_b_r;
  logic [REC_W-1:0] rec;
  logic [2:0][7:0] q_o_r;
  logic [1:0] fl_o_r;

  assign en_o  = !vo_r || out_ready;
  assign en_b  = !vb_r || en_o;
  assign en_a  = !va_r || en_b;
  assign q_pop = q_avail && en_a;

  always_comb begin
    sum_nxt = '0;
    cnt_nxt = '0;
    for (int s = 0; s < 9; s++) begin
      if (q_job.vld[s]) begin
        for (int k = 0; k < 3; k++) begin
          sum_nxt[k] = sum_nxt[k] + SUM_W'(q_job.px[s][8*k +: 8]);
        end
        cnt_nxt = cnt_nxt + CNT_W'(1);
      end
    end
  end

  assign rec = recip(cnt_a_r);

  always_ff @(posedge clk) begin
    if (en_a) begin
      sum_a_r <= sum_nxt;
      cnt_a_r <= cnt_nxt;
      fl_a_r  <= {q_job.run_last, q_job.frame_last};
    end
    if (en_b) begin
      for (int k = 0; k < 3; k++) begin
        prod_b_r[k] <= PROD_W'({sum_a_r[k], 1'b0} + NUM_W'(cnt_a_r)) * PROD_W'(rec);
      end
      fl_b_r <= fl_a_r;
    end
    if (en_o) begin
      for (int k = 0; k < 3; k++) begin
        q_o_r[k] <= prod_b_r[k][REC_SHIFT +: 8];
      end
      fl_o_r <= fl_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en_a) begin
        va_r <= q_pop;
      end
      if (en_b) begin
        vb_r <= va_r;
      end
      if (en_o) begin
        vo_r <= vb_r;
      end
    end
  end

  assign out_valid      = vo_r;
  assign out_red        = q_o_r[0];
  assign out_green      = q_o_r[1];
  assign out_blue       = q_o_r[2];
  assign out_run_last   = fl_o_r[1];
  assign out_frame_last = fl_o_r[0];

endmodule
`default_nettype wire

>>> sv/box_blur_3x3_edge_aware_core.sv
// 3x3 box blur over RGB pixels in raster order; each result is the rounded
// average of the in-frame neighbours. Output lags one row and one column: a pixel
// word gives zero, one or two results, and after the last pixel of a frame one
// drain word per column releases the bottom row, the last with out_frame_last.
// In the front a pixel word reads the line stores, then writes them back as its
// job is pushed, with a second push when it releases two results; a drain word
// reads up to two columns over the single read port of the line stores. The back
// registers sum, product and result in turn. Writing a register restarts the frame.
// depends on bb3_pkg, bb3_front, bb3_queue, bb3_back
`timescale 1ns / 1ps
`default_nettype none
module box_blur_3x3_edge_aware_core (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_we,
  input  wire [bb3_pkg::IDX_W-1:0]    cfg_index,
  input  wire [bb3_pkg::CFG_W-1:0]    cfg_data,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire                         in_mode,
  input  wire [7:0]                   in_red,
  input  wire [7:0]                   in_green,
  input  wire [7:0]                   in_blue,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [7:0]                  out_red,
  output logic [7:0]                  out_green,
  output logic [7:0]                  out_blue,
  output logic                        out_run_last,
  output logic                        out_frame_last
);
  import bb3_pkg::*;

  logic q_push, q_room, q_pop, q_avail;
  bb3_job_t push_job, pop_job;

  bb3_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .q_room    (q_room),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  bb3_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .room     (q_room),
    .pop      (q_pop),
    .avail    (q_avail),
    .pop_job  (pop_job)
  );

  bb3_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_avail        (q_avail),
    .q_job          (pop_job),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_run_last   (out_run_last),
    .out_frame_last (out_frame_last)
  );

endmodule
`default_nettype wire

>>> sv/bb3_checker.sv
// bb3_checker: port-level checks for the box blur core, bound to the top level
// depends on box_blur_3x3_edge_aware_core
`timescale 1ns / 1ps
`default_nettype none
module bb3_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] out_red,
  input wire       out_run_last,
  input wire       out_frame_last
);

  // stalled result word stays valid and keeps its red channel
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red))
    else $error("result word changed while stalled");

  // frame end is always the last result of its word
  a_frame_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_last |-> out_run_last)
    else $error("frame_last without run_last");

  // reset empties the result stage
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind box_blur_3x3_edge_aware_core bb3_checker u_bb3_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_red        (out_red),
  .out_run_last   (out_run_last),
  .out_frame_last (out_frame_last)
);
`default_nettype wire

>>> bench/testbench.sv
// testbench for box_blur_3x3_edge_aware_core: random and directed frames, a
// scoreboard class that predicts each blurred pixel and checks the result words
// depends on bb3_pkg and box_blur_3x3_edge_aware_core
`timescale 1ns / 1ps

typedef struct {
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       run_last;
  logic       frame_last;
} blur_px_t;

class blur_scoreboard;
  logic [23:0] older_row[bb3_pkg::MAX_WIDTH];
  logic [23:0] newer_row[bb3_pkg::MAX_WIDTH];
  logic [23:0] win[6];
  int row_pos, col_pos, drain_pos;
  bit awaiting_drain;
  int width_reg, height_reg;
  int acc_s[3];
  int acc_n;
  blur_px_t pending[$];
  int mismatches, results_seen, words_noted;

  function new();
    foreach (older_row[i]) older_row[i] = '0;
    foreach (newer_row[i]) newer_row[i] = '0;
    foreach (win[i]) win[i] = '0;
    width_reg = 1024;
    height_reg = 1024;
    restart();
  endfunction

  function void restart();
    row_pos = 0;
    col_pos = 0;
    drain_pos = 0;
    awaiting_drain = 0;
  endfunction

  function void write_reg(logic [bb3_pkg::IDX_W-1:0] idx, int value);
    if (idx == bb3_pkg::REG_WIDTH) width_reg = value & 'h7ff;
    else height_reg = value & 'h1fff;
    restart();
  endfunction

  function int eff_w();
    return width_reg < 1 ? 1 :
           (width_reg > bb3_pkg::MAX_WIDTH ? bb3_pkg::MAX_WIDTH : width_reg);
  endfunction

  function int eff_h();
    return height_reg < 1 ? 1 :
           (height_reg > bb3_pkg::MAX_HEIGHT ? bb3_pkg::MAX_HEIGHT : height_reg);
  endfunction

  function void clear_acc();
    acc_s = '{0, 0, 0};
    acc_n = 0;
  endfunction

  function void add_px(logic [23:0] px, bit ok);
    if (!ok) return;
    acc_s[0] += px[7:0];
    acc_s[1] += px[15:8];
    acc_s[2] += px[23:16];
    acc_n++;
  endfunction

  function void push_avg(bit rl, bit fl);
    blur_px_t e;
    int q[3];
    for (int k = 0; k < 3; k++) begin
      q[k] = acc_n == 0 ? 0 : (2 * acc_s[k] + acc_n) / (2 * acc_n);
      if (q[k] > 255) q[k] = 255;
    end
    e.red = 8'(q[0]);
    e.green = 8'(q[1]);
    e.blue = 8'(q[2]);
    e.run_last = rl;
    e.frame_last = fl;
    pending.push_back(e);
  endfunction

  function void note_word(bit mode, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int w, h, c, rr;
    bit top, two, rv;
    logic [23:0] cur[3];
    w = eff_w();
    h = eff_h();
    words_noted++;
    if (!mode) begin
      if (awaiting_drain) return;
      rr = row_pos;
      c = col_pos;
      top = rr >= 2;
      cur[0] = older_row[c];
      cur[1] = newer_row[c];
      cur[2] = {b, g, r};
      older_row[c] = newer_row[c];
      newer_row[c] = cur[2];
      if (rr >= 1) begin
        two = (c == w - 1) && (c >= 1);
        if (c >= 1) begin
          clear_acc();
          for (int i = 0; i < 3; i++) begin
            rv = (i != 0) || top;
            add_px(win[3+i], rv && c >= 2);
            add_px(win[i], rv);
            add_px(cur[i], rv);
          end
          push_avg(!two, 0);
        end
        if (c == w - 1) begin
          clear_acc();
          for (int i = 0; i < 3; i++) begin
            rv = (i != 0) || top;
            add_px(win[i], rv && c >= 1);
            add_px(cur[i], rv);
          end
          push_avg(1, 0);
        end
      end
      for (int i = 0; i < 3; i++) begin
        win[3+i] = win[i];
        win[i] = cur[i];
      end
      c++;
      if (c >= w) begin
        c = 0;
        rr++;
        if (rr >= h) begin
          rr = 0;
          awaiting_drain = 1;
        end
      end
      row_pos = rr;
      col_pos = c;
    end else begin
      if (!awaiting_drain || drain_pos >= w) return;
      clear_acc();
      for (int k = 0; k < 3; k++) begin
        if ((k == 0 && drain_pos >= 1) || k == 1 || (k == 2 && drain_pos + 1 < w)) begin
          add_px(older_row[drain_pos+k-1], h >= 2);
          add_px(newer_row[drain_pos+k-1], 1);
        end
      end
      push_avg(1, drain_pos == w - 1);
      drain_pos++;
      if (drain_pos >= w) restart();
    end
  endfunction

  function void check_result(blur_px_t got);
    blur_px_t e;
    results_seen++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result word r=%0d g=%0d b=%0d",
                                     got.red, got.green, got.blue);
      return;
    end
    e = pending.pop_front();
    if (got.red !== e.red || got.green !== e.green || got.blue !== e.blue ||
        got.run_last !== e.run_last || got.frame_last !== e.frame_last) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch: exp r=%0d g=%0d b=%0d rl=%0b fl=%0b, ",
                  "got r=%0d g=%0d b=%0d rl=%0b fl=%0b"},
                 e.red, e.green, e.blue, e.run_last, e.frame_last,
                 got.red, got.green, got.blue, got.run_last, got.frame_last);
    end
  endfunction
endclass

module testbench;
  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [bb3_pkg::IDX_W-1:0] cfg_index = '0;
  logic [bb3_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic in_mode = 0;
  logic [7:0] in_red = '0, in_green = '0, in_blue = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [7:0] out_red, out_green, out_blue;
  logic out_run_last, out_frame_last;

  blur_scoreboard sb;
  int tx_idle_pct = 32;
  int rx_idle_pct = 55;
  int hold_req = 0;
  int hold_left = 0;
  int frames_done = 0;

  box_blur_3x3_edge_aware_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_run_last(out_run_last), .out_frame_last(out_frame_last)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else if (hold_req > 0 || hold_left > 0) begin
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      hold_left--;
      out_ready <= 0;
    end else begin
      out_ready <= $urandom_range(99) >= rx_idle_pct;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      blur_px_t got;
      got.red = out_red;
      got.green = out_green;
      got.blue = out_blue;
      got.run_last = out_run_last;
      got.frame_last = out_frame_last;
      sb.check_result(got);
    end
  end

  initial begin
    #40ms;
    $display("box_blur_3x3_edge_aware_core test failed");
    $finish;
  end

  task automatic send_word(bit mode, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_mode <= mode;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_word(mode, r, g, b);
    if (sb.words_noted == 550) begin
      tx_idle_pct = 55;
      rx_idle_pct = 32;
    end else if (sb.words_noted == 1100) begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_frame(int w, int h);
    wait_drained();
    cfg_we <= 1;
    cfg_index <= bb3_pkg::REG_WIDTH;
    cfg_data <= bb3_pkg::CFG_W'(w);
    @(posedge clk);
    sb.write_reg(bb3_pkg::REG_WIDTH, w);
    cfg_index <= bb3_pkg::REG_HEIGHT;
    cfg_data <= bb3_pkg::CFG_W'(h);
    @(posedge clk);
    sb.write_reg(bb3_pkg::REG_HEIGHT, h);
    cfg_we <= 0;
  endtask

  function automatic logic [7:0] pick_chan();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(255));
  endfunction

  // one frame of pixels and drains, noise words mixed in at noise_pct
  task automatic run_frame(int noise_pct, bit mid_pause);
    int w, h;
    w = sb.eff_w();
    h = sb.eff_h();
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(99) < noise_pct)
        send_word(1, rnd8(), rnd8(), rnd8());
      if (mid_pause && i == (w * h) / 2) wait_drained();
      send_word(0, pick_chan(), pick_chan(), pick_chan());
    end
    for (int d = 0; d < w; d++) begin
      if ($urandom_range(99) < noise_pct)
        send_word(0, rnd8(), rnd8(), rnd8());
      send_word(1, rnd8(), rnd8(), rnd8());
    end
    frames_done++;
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: tiny frames with extreme pixels and ignored words
    set_frame(3, 3);
    send_word(1, 8'hff, 8'h00, 8'hff);
    send_word(0, 8'hff, 8'hff, 8'hff);
    send_word(0, 8'h00, 8'h00, 8'h00);
    for (int i = 0; i < 7; i++) send_word(0, 8'hff, 8'h00, 8'hff);
    send_word(0, 8'h12, 8'h34, 8'h56);
    for (int i = 0; i < 3; i++) send_word(1, 8'h00, 8'hff, 8'h00);
    frames_done++;
    set_frame(0, 0);
    run_frame(0, 0);
    set_frame(2, 1);
    run_frame(0, 0);
    set_frame(1, 3);
    run_frame(0, 0);

    // random small frames, one with a long receiver hold-off
    while (sb.words_noted < 420) begin
      set_frame($urandom_range(1, 9), $urandom_range(1, 7));
      if (frames_done == 6) hold_req = 300;
      run_frame(4, frames_done == 9);
    end

    // clamped width: a full 1024-pixel row, then part of the next row
    set_frame(2047, 8191);
    for (int i = 0; i < 1084; i++) send_word(0, pick_chan(), pick_chan(), pick_chan());

    // a wider random frame to finish
    set_frame($urandom_range(10, 30), $urandom_range(2, 3));
    run_frame(2, 0);

    wait_drained();
    $display("covered %0d frames plus a clamped wide row, %0d input words, %0d results checked",
             frames_done, sb.words_noted, sb.results_seen);
    $display("mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0)
      $display("box_blur_3x3_edge_aware_core test passed");
    else
      $display("box_blur_3x3_edge_aware_core test failed");
    $finish;
  end
endmodule
